// File: hw/rtl/uteac_pkg.sv
// Types, codes and codepoint class functions for the UTF-8 emoji classifier.
// No dependencies; used by the step logic, the top level and the checker.
`timescale 1ns / 1ps

package uteac_pkg;

  localparam int unsigned CpWidth   = 21;
  localparam int unsigned ByteWidth = 8;

  localparam logic [CpWidth-1:0] CpZwj  = 21'h0200D;
  localparam logic [CpWidth-1:0] CpHeart = 21'h02764;

  // result class of one codepoint
  typedef enum logic [2:0] {
    KindMeasure  = 3'd0,
    KindZwj      = 3'd1,
    KindMark     = 3'd2,
    KindComposed = 3'd3,
    KindNone     = 3'd4
  } kind_e;

  // decoder state carried from byte to byte
  typedef struct packed {
    logic [1:0]         bytes_pending;
    logic [CpWidth-1:0] partial_code;
    logic               after_joiner;
    logic               prev_is_base;
  } state_t;

  // one result word, with a flag saying whether the byte produced it
  typedef struct packed {
    logic               emit;
    logic [CpWidth-1:0] codepoint;
    kind_e              kind;
    logic               end_of_text;
  } result_t;

  // skin tone modifiers, variation selectors and the keycap mark
  function automatic logic is_mark(logic [CpWidth-1:0] c);
    is_mark = (c inside {[21'h1F3FB:21'h1F3FF]}) ||
              (c inside {21'h0FE0E, 21'h0FE0F, 21'h020E3});
  endfunction

  // codepoints that may follow a joiner as part of one emoji
  function automatic logic emoji_joinable(logic [CpWidth-1:0] c);
    emoji_joinable = (c inside {[21'h1F000:21'h1FFFF], [21'h02600:21'h027BF],
                                [21'h02300:21'h023FF], [21'h02B00:21'h02BFF]}) ||
                     (c == CpZwj) || (c == CpHeart);
  endfunction

  // codepoints that may start a joiner sequence
  function automatic logic composition_base(logic [CpWidth-1:0] c);
    composition_base = (c inside {[21'h1F466:21'h1F469], [21'h1F3F3:21'h1F3F4]}) ||
                       (c inside {21'h1F9D1, 21'h1F441, 21'h1F408, 21'h1F415,
                                  21'h1F43B, 21'h1F426, 21'h1F48B, CpHeart});
  endfunction

endpackage

// File: hw/rtl/utf8_emoji_advance_classifier.sv
// Top level of the UTF-8 emoji classifier: input register, decoder state,
// result register. Depends on uteac_pkg and uteac_step.
`timescale 1ns / 1ps

// Takes UTF-8 text one byte per word and returns one word per decoded
// codepoint with its class (measure, ZWJ, combining mark, composed after
// ZWJ); the word for the last byte of a text is flagged end_of_text and
// carries a partial codepoint if the text ends mid sequence, or kind
// none if the last byte is a stray byte. Bytes are taken at one per clock
// while the sink keeps up; each byte is held in the input register and its
// result in the result register behind it. The rate is set by the single
// decode/classify step between the two registers, which updates the decoder
// state for each byte that moves on. A result not taken by the sink stalls
// the input after one more byte has been buffered. The decoder state returns
// to reset after the last byte.
module utf8_emoji_advance_classifier
  import uteac_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  input  logic               last_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CpWidth-1:0] codepoint_o,
  output logic [2:0]         kind_o,
  output logic               end_of_text_o
);

  logic                 in_valid_q;
  logic [ByteWidth-1:0] byte_q;
  logic                 last_q;
  state_t               state_q, state_d;
  result_t              result_d;
  logic                 out_valid_q;
  logic [CpWidth-1:0]   codepoint_q;
  kind_e                kind_q;
  logic                 eot_q;
  logic                 advance;

  // the buffered byte moves on when the result register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
      last_q <= last_byte_i;
    end
  end

  uteac_step u_step (
    .state_i  (state_q),
    .byte_i   (byte_q),
    .last_i   (last_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= result_d.emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && result_d.emit) begin
      codepoint_q <= result_d.codepoint;
      kind_q      <= result_d.kind;
      eot_q       <= result_d.end_of_text;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign codepoint_o   = codepoint_q;
  assign kind_o        = kind_q;
  assign end_of_text_o = eot_q;

endmodule

// File: hw/rtl/uteac_step.sv
// Per-byte decode and classification: next decoder state and the result word.
// Pure combinational logic; depends on uteac_pkg.
`timescale 1ns / 1ps

module uteac_step
  import uteac_pkg::*;
(
  input  state_t               state_i,
  input  logic [ByteWidth-1:0] byte_i,
  input  logic                 last_i,
  output state_t               state_o,
  output result_t              result_o
);

  logic [1:0]         pend;
  logic [CpWidth-1:0] code;
  logic               have;
  logic               cut_short;
  logic               join_flag;
  logic               base_flag;
  kind_e              kind;

  // utf-8 byte decode
  always_comb begin
    pend = state_i.bytes_pending;
    code = state_i.partial_code;
    have = 1'b0;
    if (state_i.bytes_pending != 2'd0) begin
      code = {state_i.partial_code[CpWidth-7:0], byte_i[5:0]};
      pend = state_i.bytes_pending - 2'd1;
      have = (pend == 2'd0);
    end else if (byte_i[7] == 1'b0) begin
      code = {{(CpWidth-ByteWidth){1'b0}}, byte_i};
      have = 1'b1;
    end else if (byte_i[7:5] == 3'b110) begin
      code = {{(CpWidth-5){1'b0}}, byte_i[4:0]};
      pend = 2'd1;
    end else if (byte_i[7:4] == 4'b1110) begin
      code = {{(CpWidth-4){1'b0}}, byte_i[3:0]};
      pend = 2'd2;
    end else if (byte_i[7:3] == 5'b11110) begin
      code = {{(CpWidth-3){1'b0}}, byte_i[2:0]};
      pend = 2'd3;
    end
    cut_short = last_i && (pend != 2'd0);
  end

  // classify the finished codepoint and update the joiner flags
  always_comb begin
    join_flag = state_i.after_joiner;
    base_flag = state_i.prev_is_base;
    kind      = KindMeasure;
    if (code == CpZwj) begin
      kind = KindZwj;
      if (state_i.prev_is_base) begin
        join_flag = 1'b1;
      end
    end else if (is_mark(code)) begin
      kind = KindMark;
    end else begin
      join_flag = 1'b0;
      base_flag = composition_base(code);
      if (state_i.after_joiner && emoji_joinable(code)) begin
        kind = KindComposed;
      end
    end
  end

  // next state and result word
  always_comb begin
    result_o.emit        = have || cut_short || last_i;
    result_o.codepoint   = (have || cut_short) ? code : '0;
    result_o.kind        = (have || cut_short) ? kind : KindNone;
    result_o.end_of_text = last_i;

    state_o = state_i;
    state_o.bytes_pending = pend;
    state_o.partial_code  = code;
    if (have || cut_short) begin
      state_o.bytes_pending = 2'd0;
      state_o.partial_code  = '0;
      state_o.after_joiner  = join_flag;
      state_o.prev_is_base  = base_flag;
    end
    if (last_i) begin
      state_o = '0;
    end
  end

endmodule

// File: hw/rtl/uteac_checker.sv
// Port-level checks for the UTF-8 emoji classifier, bound to the top level.
// Depends on uteac_pkg.
`timescale 1ns / 1ps

module uteac_checker
  import uteac_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [CpWidth-1:0] codepoint_o,
  input logic [2:0]         kind_o,
  input logic               end_of_text_o
);

  // a byte word once offered stays offered until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i)
    else $error("byte word withdrawn while stalled");

  // a stalled result word stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // kind none only on the end-of-text word, with an empty codepoint
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KindNone) |-> end_of_text_o && (codepoint_o == '0))
    else $error("kind none outside end of text");

  // a joiner word carries the joiner codepoint
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KindZwj) |-> (codepoint_o == CpZwj))
    else $error("joiner kind with wrong codepoint");

  // a composed word is always an emoji that can follow a joiner
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KindComposed) |-> emoji_joinable(codepoint_o))
    else $error("composed kind on a non-emoji codepoint");

endmodule

bind utf8_emoji_advance_classifier uteac_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .codepoint_o   (codepoint_o),
  .kind_o        (kind_o),
  .end_of_text_o (end_of_text_o)
);

// File: verif/uteac_glyph_checker.sv
// Checker for the UTF-8 emoji classifier: watches both word channels, predicts
// each result word from the accepted bytes and compares. Depends on uteac_pkg.
`timescale 1ns / 1ps

module uteac_glyph_checker
  import uteac_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [7:0]         in_byte_i,
  input  logic               last_byte_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [CpWidth-1:0] codepoint_i,
  input  logic [2:0]         kind_i,
  input  logic               end_of_text_i,
  output int unsigned        mismatches_o,
  output int unsigned        outstanding_o
);

  typedef struct packed {
    logic [CpWidth-1:0] codepoint;
    kind_e              kind;
    logic               end_of_text;
  } glyph_t;

  // words still owed by the block, oldest first
  glyph_t glyph_queue[$];

  // decoder state as predicted
  logic [1:0]         cont_left    = '0;
  logic [CpWidth-1:0] code_acc     = '0;
  logic               joiner_armed = 1'b0;
  logic               base_seen    = 1'b0;

  initial begin
    mismatches_o  = 0;
    outstanding_o = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns checker: %s", $realtime, msg);
    mismatches_o = mismatches_o + 1;
  endtask

  // skin tones, variation selectors, keycap
  function automatic logic is_modifier(input logic [CpWidth-1:0] c);
    return (c >= 21'h1F3FB && c <= 21'h1F3FF) || c == 21'h0FE0E ||
           c == 21'h0FE0F || c == 21'h020E3;
  endfunction

  // emoji that merge into the one before a joiner
  function automatic logic joins_after_zwj(input logic [CpWidth-1:0] c);
    return (c >= 21'h1F000 && c <= 21'h1FFFF) || (c >= 21'h02600 && c <= 21'h027BF) ||
           (c >= 21'h02300 && c <= 21'h023FF) || (c >= 21'h02B00 && c <= 21'h02BFF) ||
           c == 21'h0200D || c == 21'h02764;
  endfunction

  // emoji that may lead a joiner sequence
  function automatic logic starts_sequence(input logic [CpWidth-1:0] c);
    return (c >= 21'h1F466 && c <= 21'h1F469) || c == 21'h1F9D1 || c == 21'h1F441 ||
           c == 21'h1F3F3 || c == 21'h1F3F4 || c == 21'h1F408 || c == 21'h1F415 ||
           c == 21'h1F43B || c == 21'h1F426 || c == 21'h1F48B || c == 21'h02764;
  endfunction

  // class of one codepoint, updating the joiner flags
  function automatic kind_e classify_code(input logic [CpWidth-1:0] c);
    kind_e k;
    k = KindMeasure;
    if (c == 21'h0200D) begin
      if (base_seen) joiner_armed = 1'b1;
      k = KindZwj;
    end else if (is_modifier(c)) begin
      k = KindMark;
    end else begin
      if (joiner_armed) begin
        joiner_armed = 1'b0;
        if (joins_after_zwj(c)) k = KindComposed;
      end
      base_seen = starts_sequence(c);
    end
    return k;
  endfunction

  // predict the word, if any, caused by one accepted byte
  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic   have;
    glyph_t g;
    have          = 1'b0;
    g.codepoint   = '0;
    g.kind        = KindNone;
    g.end_of_text = last;
    if (cont_left != 0) begin
      code_acc  = {code_acc[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      have      = (cont_left == 0);
    end else if (!b[7]) begin
      code_acc = {14'd0, b[6:0]};
      have     = 1'b1;
    end else if (b[7:5] == 3'b110) begin
      code_acc  = {16'd0, b[4:0]};
      cont_left = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      code_acc  = {17'd0, b[3:0]};
      cont_left = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      code_acc  = {18'd0, b[2:0]};
      cont_left = 2'd3;
    end
    // text ends mid sequence: emit what was gathered
    if (last && cont_left != 0) have = 1'b1;
    if (have) begin
      g.codepoint = code_acc;
      g.kind      = classify_code(code_acc);
      cont_left   = '0;
      code_acc    = '0;
    end
    if (last) begin
      cont_left    = '0;
      code_acc     = '0;
      joiner_armed = 1'b0;
      base_seen    = 1'b0;
    end
    if (have || last) glyph_queue.push_back(g);
  endtask

  // compare outgoing words, then predict from incoming bytes
  always @(posedge clk_i or negedge rst_ni) begin
    glyph_t exp_g;
    if (!rst_ni) begin
      cont_left    = '0;
      code_acc     = '0;
      joiner_armed = 1'b0;
      base_seen    = 1'b0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (glyph_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected word cp=%h kind=%0d end=%0b",
                                    codepoint_i, kind_i, end_of_text_i));
        end else begin
          exp_g = glyph_queue.pop_front();
          if (codepoint_i !== exp_g.codepoint)
            report_mismatch($sformatf("codepoint %h, expected %h",
                                      codepoint_i, exp_g.codepoint));
          if (kind_i !== exp_g.kind)
            report_mismatch($sformatf("kind %0d, expected %0d (cp %h)",
                                      kind_i, exp_g.kind, exp_g.codepoint));
          if (end_of_text_i !== exp_g.end_of_text)
            report_mismatch($sformatf("end_of_text %0b, expected %0b (cp %h)",
                                      end_of_text_i, exp_g.end_of_text, exp_g.codepoint));
        end
      end
      if (in_valid_i && in_ready_i) decode_byte(in_byte_i, last_byte_i);
    end
    outstanding_o = glyph_queue.size();
  end

endmodule

// File: verif/testbench.sv
// Top of the UTF-8 emoji classifier testbench: clock, reset, byte and result
// traffic, timeout and verdict. Depends on uteac_pkg and uteac_glyph_checker.
`timescale 1ns / 1ps

module testbench
  import uteac_pkg::*;
();

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned TargetBytes = 1500;
  localparam int unsigned HoldAtWord  = 300;
  localparam int unsigned HoldCycles  = 250;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [7:0]         in_byte_i   = '0;
  logic               last_byte_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [CpWidth-1:0] codepoint_o;
  logic [2:0]         kind_o;
  logic               end_of_text_o;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned sent_bytes = 0;
  int unsigned cycles     = 0;
  logic        tx_steady  = 1'b0;

  always #6 clk_i = ~clk_i;

  utf8_emoji_advance_classifier DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .codepoint_o  (codepoint_o),
    .kind_o       (kind_o),
    .end_of_text_o(end_of_text_o)
  );

  uteac_glyph_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .codepoint_i  (codepoint_o),
    .kind_i       (kind_o),
    .end_of_text_i(end_of_text_o),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding)
  );

  // timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL utf8_emoji_advance_classifier");
      $finish;
    end
  end

  // offer one byte word after a random gap and wait for its acceptance
  task automatic send_word(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_byte_i   <= b;
    last_byte_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_bytes = sent_bytes + 1;
  endtask

  // encode and send one codepoint; sometimes overlong, sloppy or cut short
  task automatic send_codepoint(input logic [CpWidth-1:0] cp);
    logic [7:0] seq [4];
    int         len;
    int         cut;
    logic       end_here;
    int         i;
    if (cp < 21'h80) len = 1;
    else if (cp < 21'h800) len = 2;
    else if (cp < 21'h10000) len = 3;
    else len = 4;
    if (len < 4 && $urandom_range(0, 15) == 0) len = int'($urandom_range(len + 1, 4));
    case (len)
      1: seq[0] = {1'b0, cp[6:0]};
      2: seq[0] = {3'b110, cp[10:6]};
      3: seq[0] = {4'b1110, cp[15:12]};
      default: seq[0] = {5'b11110, cp[20:18]};
    endcase
    seq[1] = {2'b10, (len == 2) ? cp[5:0] : (len == 3) ? cp[11:6] : cp[17:12]};
    seq[2] = {2'b10, (len == 3) ? cp[5:0] : cp[11:6]};
    seq[3] = {2'b10, cp[5:0]};
    // continuation bytes are not checked by the block
    for (i = 1; i < 4; i++)
      if ($urandom_range(0, 7) == 0) seq[i][7:6] = 2'($urandom_range(0, 3));
    cut      = (len > 1 && $urandom_range(0, 24) == 0) ? int'($urandom_range(0, len - 2)) : -1;
    end_here = (cut < 0) && ($urandom_range(0, 19) == 0);
    i = 0;
    while (i < len) begin
      send_word(seq[i], (i == cut) || (i == len - 1 && end_here));
      i = (i == cut) ? len : i + 1;
    end
  endtask

  function automatic logic [CpWidth-1:0] base_code(input int unsigned idx);
    case (idx)
      0: return 21'h1F466;
      1: return 21'h1F467;
      2: return 21'h1F468;
      3: return 21'h1F469;
      4: return 21'h1F9D1;
      5: return 21'h1F441;
      6: return 21'h1F3F3;
      7: return 21'h1F3F4;
      8: return 21'h1F408;
      9: return 21'h1F415;
      10: return 21'h1F43B;
      11: return 21'h1F426;
      12: return 21'h1F48B;
      default: return CpHeart;
    endcase
  endfunction

  function automatic logic [CpWidth-1:0] mark_code();
    case ($urandom_range(0, 3))
      0: return 21'($urandom_range(21'h1F3FB, 21'h1F3FF));
      1: return 21'h0FE0E;
      2: return 21'h0FE0F;
      default: return 21'h020E3;
    endcase
  endfunction

  function automatic logic [CpWidth-1:0] joinable_code();
    case ($urandom_range(0, 3))
      0: return 21'($urandom_range(21'h1F000, 21'h1FFFF));
      1: return 21'($urandom_range(21'h02600, 21'h027BF));
      2: return 21'($urandom_range(21'h02300, 21'h023FF));
      default: return 21'($urandom_range(21'h02B00, 21'h02BFF));
    endcase
  endfunction

  // codepoints just inside or outside the class boundaries
  function automatic logic [CpWidth-1:0] boundary_code();
    case ($urandom_range(0, 19))
      0: return 21'h1EFFF;
      1: return 21'h1F000;
      2: return 21'h1FFFF;
      3: return 21'h20000;
      4: return 21'h025FF;
      5: return 21'h027C0;
      6: return 21'h022FF;
      7: return 21'h02400;
      8: return 21'h02AFF;
      9: return 21'h02C00;
      10: return 21'h1F3FA;
      11: return 21'h1F400;
      12: return 21'h1F465;
      13: return 21'h1F46A;
      14: return 21'h0FE0D;
      15: return 21'h0FE10;
      16: return 21'h020E2;
      17: return 21'h020E4;
      18: return 21'h0200C;
      default: return 21'h0200E;
    endcase
  endfunction

  function automatic logic [CpWidth-1:0] any_code();
    case ($urandom_range(0, 9))
      0, 1: return 21'($urandom_range(0, 127));
      2: return base_code($urandom_range(0, 13));
      3: return CpZwj;
      4: return mark_code();
      5: return joinable_code();
      6: return boundary_code();
      7: return 21'($urandom_range(0, 21'h7FF));
      8: return 21'($urandom_range(0, 21'hFFFF));
      default: return 21'($urandom_range(0, 21'h1FFFFF));
    endcase
  endfunction

  // result side: random ready gaps, steady stretches, one long hold-off
  initial begin : sink
    int unsigned gap;
    int unsigned words_taken;
    logic        rx_steady;
    words_taken = 0;
    rx_steady   = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (words_taken % 100 == 0) rx_steady = ($urandom_range(0, 3) == 0);
      gap = rx_steady ? 0 : $urandom_range(0, 12);
      if (words_taken == HoldAtWord) gap = HoldCycles;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      words_taken++;
    end
  end

  // byte side and verdict
  initial begin : source
    int unsigned chunk;
    int unsigned n;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: ascii extremes, two byte max
    send_word(8'h00, 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(8'hDF, 1'b0);
    send_word(8'hBF, 1'b0);
    // base, joiner, composed emoji, variation selector
    send_word(8'hF0, 1'b0);
    send_word(8'h9F, 1'b0);
    send_word(8'h91, 1'b0);
    send_word(8'hA8, 1'b0);
    send_word(8'hE2, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h8D, 1'b0);
    send_word(8'hF0, 1'b0);
    send_word(8'h9F, 1'b0);
    send_word(8'h91, 1'b0);
    send_word(8'hA9, 1'b0);
    send_word(8'hEF, 1'b0);
    send_word(8'hB8, 1'b0);
    send_word(8'h8F, 1'b0);
    // stray bytes skipped, then a stray byte ending the text
    send_word(8'hFF, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'hF8, 1'b1);
    // text cut short inside a four byte sequence
    send_word(8'hF4, 1'b0);
    send_word(8'h8F, 1'b1);

    // random text: joiner chains, single codepoints, noise
    chunk = 0;
    while (sent_bytes < TargetBytes) begin
      if (sent_bytes / 100 != chunk) begin
        chunk     = sent_bytes / 100;
        tx_steady = ($urandom_range(0, 3) == 0);
      end
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          send_codepoint(base_code($urandom_range(0, 13)));
          if ($urandom_range(0, 2) == 0) send_codepoint(mark_code());
          send_codepoint(CpZwj);
          if ($urandom_range(0, 1) == 0) send_codepoint(joinable_code());
          else send_codepoint(any_code());
        end
        3: begin
          n = $urandom_range(1, 3);
          repeat (n) send_word(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        end
        default: send_codepoint(any_code());
      endcase
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    // drain, then allow for the pipeline
    wait (outstanding == 0);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS utf8_emoji_advance_classifier");
    end else begin
      $display("FAIL utf8_emoji_advance_classifier");
    end
    $finish;
  end

endmodule
